// ===== hdl/mwlm_pkg.sv =====
package mwlm_pkg;

  // Field widths
  localparam int unsigned TW  = 27;   // thickness
  localparam int unsigned DW  = 18;   // density
  localparam int unsigned PW  = 17;   // temperature, dendricity, sphericity
  localparam int unsigned GW  = 24;   // grain size

  // Datapath widths
  localparam int unsigned MW   = TW + DW;       // one layer mass
  localparam int unsigned MTW  = MW + 1;        // total mass
  localparam int unsigned VW   = GW;            // widest averaged value
  localparam int unsigned NUMW = VW + MW + 1;   // weighted sum
  localparam int unsigned QW   = VW;            // quotient bits, one per divider stage
  localparam int unsigned SPL  = 23;            // mass split point for the products

  // Divider lanes
  localparam int unsigned NFLD  = 4;
  localparam int unsigned NLANE = NFLD + 1;
  localparam int unsigned L_TEMP  = 0;
  localparam int unsigned L_DEND  = 1;
  localparam int unsigned L_SPHER = 2;
  localparam int unsigned L_GRAIN = 3;
  localparam int unsigned L_DENS  = 4;

  localparam logic [TW:0] THICK_MAX = (TW+1)'(100000000);

  typedef struct packed {
    logic [TW-1:0] thick_a;
    logic [DW-1:0] dens_a;
    logic [PW-1:0] temp_a;
    logic [PW-1:0] dend_a;
    logic [PW-1:0] spher_a;
    logic [GW-1:0] grain_a;
    logic [TW-1:0] thick_b;
    logic [DW-1:0] dens_b;
    logic [PW-1:0] temp_b;
    logic [PW-1:0] dend_b;
    logic [PW-1:0] spher_b;
    logic [GW-1:0] grain_b;
  } in_t;

  typedef struct packed {
    logic [TW-1:0] thick_out;
    logic [DW-1:0] dens_out;
    logic [PW-1:0] temp_out;
    logic [PW-1:0] dend_out;
    logic [PW-1:0] spher_out;
    logic [GW-1:0] grain_out;
    logic          zero_mass;
  } out_t;

  // One division request: num / den
  typedef struct packed {
    logic [NUMW-1:0] num;
    logic [MTW-1:0]  den;
  } div_req_t;

  // Values that bypass the dividers
  typedef struct packed {
    logic [TW-1:0] thick;
    logic          zero;
    logic [PW-1:0] temp;
    logic [PW-1:0] dend;
    logic [PW-1:0] spher;
    logic [GW-1:0] grain;
  } side_t;

  // Averaged field f of layer A / layer B, zero extended
  function automatic logic [VW-1:0] field_a(in_t d, logic [1:0] f);
    logic [VW-1:0] v;
    unique case (f)
      2'(L_TEMP):  v = VW'(d.temp_a);
      2'(L_DEND):  v = VW'(d.dend_a);
      2'(L_SPHER): v = VW'(d.spher_a);
      default:     v = d.grain_a;
    endcase
    return v;
  endfunction

  function automatic logic [VW-1:0] field_b(in_t d, logic [1:0] f);
    logic [VW-1:0] v;
    unique case (f)
      2'(L_TEMP):  v = VW'(d.temp_b);
      2'(L_DEND):  v = VW'(d.dend_b);
      2'(L_SPHER): v = VW'(d.spher_b);
      default:     v = d.grain_b;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/mwlm_front.sv =====
module mwlm_front (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         en_i,
  input  logic                                         vld_i,
  input  mwlm_pkg::in_t                                data_i,
  output logic                                         vld_o,
  output mwlm_pkg::div_req_t [mwlm_pkg::NLANE-1:0]     req_o,
  output mwlm_pkg::side_t                              side_o
);
  import mwlm_pkg::*;

  // Stage 1: layer masses
  logic          vld1_q;
  logic [MW-1:0] ma1_q, mb1_q;
  in_t           in1_q;

  // Stage 2: total mass, split products
  logic                  vld2_q;
  logic [MTW-1:0]        mt2_q;
  logic [TW:0]           tsum2_q;
  logic [VW+SPL-1:0]     lo_a2_q [NFLD];
  logic [VW+SPL-1:0]     lo_b2_q [NFLD];
  logic [VW+MW-SPL-1:0]  hi_a2_q [NFLD];
  logic [VW+MW-SPL-1:0]  hi_b2_q [NFLD];
  side_t                 side2_q;

  // Stage 3: weighted sums
  logic                         vld3_q;
  div_req_t [NLANE-1:0]         req3_q;
  side_t                        side3_q;

  logic [MTW-1:0] mt2_d;
  logic [TW:0]    tsum2_d;
  side_t          side2_d;
  div_req_t [NLANE-1:0] req3_d;

  // Stage 2 sums and bypass values
  always_comb begin
    mt2_d   = MTW'(ma1_q) + MTW'(mb1_q);
    tsum2_d = (TW+1)'(in1_q.thick_a) + (TW+1)'(in1_q.thick_b);
    side2_d.thick = (tsum2_d > THICK_MAX) ? THICK_MAX[TW-1:0] : tsum2_d[TW-1:0];
    side2_d.zero  = (mt2_d == '0);
    side2_d.temp  = in1_q.temp_a;
    side2_d.dend  = in1_q.dend_a;
    side2_d.spher = in1_q.spher_a;
    side2_d.grain = in1_q.grain_a;
  end

  // Stage 3 division requests
  always_comb begin
    for (int f = 0; f < NFLD; f++) begin
      req3_d[f].num = NUMW'(lo_a2_q[f]) + (NUMW'(hi_a2_q[f]) << SPL)
                    + NUMW'(lo_b2_q[f]) + (NUMW'(hi_b2_q[f]) << SPL);
      req3_d[f].den = mt2_q;
    end
    req3_d[L_DENS].num = NUMW'(mt2_q);
    req3_d[L_DENS].den = MTW'(tsum2_q);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma1_q <= MW'(data_i.thick_a) * MW'(data_i.dens_a);
      mb1_q <= MW'(data_i.thick_b) * MW'(data_i.dens_b);
      in1_q <= data_i;

      mt2_q   <= mt2_d;
      tsum2_q <= tsum2_d;
      side2_q <= side2_d;
      for (int f = 0; f < NFLD; f++) begin
        lo_a2_q[f] <= (VW+SPL)'(field_a(in1_q, 2'(f))) * (VW+SPL)'(ma1_q[SPL-1:0]);
        lo_b2_q[f] <= (VW+SPL)'(field_b(in1_q, 2'(f))) * (VW+SPL)'(mb1_q[SPL-1:0]);
        hi_a2_q[f] <= (VW+MW-SPL)'(field_a(in1_q, 2'(f)))
                    * (VW+MW-SPL)'(ma1_q[MW-1:SPL]);
        hi_b2_q[f] <= (VW+MW-SPL)'(field_b(in1_q, 2'(f)))
                    * (VW+MW-SPL)'(mb1_q[MW-1:SPL]);
      end

      req3_q  <= req3_d;
      side3_q <= side2_q;
    end
  end

  assign vld_o  = vld3_q;
  assign req_o  = req3_q;
  assign side_o = side3_q;

endmodule

// ===== hdl/mwlm_div_lane.sv =====
module mwlm_div_lane (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  mwlm_pkg::div_req_t           req_i,
  output logic [mwlm_pkg::QW-1:0]      quo_o
);
  import mwlm_pkg::*;

  // Restoring division, one quotient bit per stage.
  // Quotient is known to fit QW bits, so the top part starts below den.
  logic [MTW-1:0] rem_q [QW];
  logic [QW-1:0]  nlo_q [QW];
  logic [MTW-1:0] den_q [QW];
  logic [QW-1:0]  quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [MTW-1:0] rem_in, den_in;
    logic [QW-1:0]  nlo_in, quo_in;
    logic [MTW:0]   sh, diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in = req_i.num[NUMW-1:QW];
      assign nlo_in = req_i.num[QW-1:0];
      assign den_in = req_i.den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nlo_in = nlo_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // shift in next numerator bit, trial subtract
    assign sh   = {rem_in, nlo_in[QW-1]};
    assign diff = sh - {1'b0, den_in};
    assign ge   = (sh >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[MTW-1:0] : sh[MTW-1:0];
        nlo_q[k] <= {nlo_in[QW-2:0], 1'b0};
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// ===== hdl/mass_weighted_layer_merge.sv =====
// Merges two snow layers into one: thickness is the saturated sum, density the
// total mass over total thickness, and temperature, dendricity, sphericity and
// grain size the mass-weighted averages, all truncated. Zero total mass passes
// layer A through with density zero and zero_mass set. Fully pipelined: one
// request per cycle while in_stall_o is low. The pipe holds three front stages
// (masses, products, sums) and the 24-stage restoring dividers, one quotient
// bit per stage, five lanes side by side, ahead of the output register. Output
// stalls only hold the pipe once the skid register is full.
// A skid register behind the output lets a request enter while a result waits.
module mass_weighted_layer_merge (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mwlm_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mwlm_pkg::out_t   out_data_o
);
  import mwlm_pkg::*;

  logic                 en;
  logic                 take;
  logic                 front_vld;
  div_req_t [NLANE-1:0] req;
  side_t                front_side;
  logic [QW-1:0]        quo [NLANE];

  logic  vld_q  [QW];
  side_t side_q [QW];

  out_t  pipe_res;
  out_t  out_q, skid_q;
  logic  out_vld_q, skid_vld_q;

  assign en         = !skid_vld_q;
  assign take       = out_vld_q && !out_stall_i;
  assign in_stall_o = skid_vld_q;

  mwlm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .data_i (in_data_i),
    .vld_o  (front_vld),
    .req_o  (req),
    .side_o (front_side)
  );

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    mwlm_div_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .req_i (req[l]),
      .quo_o (quo[l])
    );
  end

  // Valid and bypass values alongside the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QW; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= front_vld;
      for (int k = 1; k < QW; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= front_side;
      for (int k = 1; k < QW; k++) side_q[k] <= side_q[k-1];
    end
  end

  // Result assembly
  always_comb begin
    pipe_res.thick_out = side_q[QW-1].thick;
    pipe_res.zero_mass = side_q[QW-1].zero;
    if (side_q[QW-1].zero) begin
      pipe_res.dens_out  = '0;
      pipe_res.temp_out  = side_q[QW-1].temp;
      pipe_res.dend_out  = side_q[QW-1].dend;
      pipe_res.spher_out = side_q[QW-1].spher;
      pipe_res.grain_out = side_q[QW-1].grain;
    end else begin
      pipe_res.dens_out  = quo[L_DENS][DW-1:0];
      pipe_res.temp_out  = quo[L_TEMP][PW-1:0];
      pipe_res.dend_out  = quo[L_DEND][PW-1:0];
      pipe_res.spher_out = quo[L_SPHER][PW-1:0];
      pipe_res.grain_out = quo[L_GRAIN][GW-1:0];
    end
  end

  // Output register and skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) skid_vld_q <= 1'b0;
    end else begin
      if (vld_q[QW-1] && out_vld_q && !take) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= vld_q[QW-1] || (out_vld_q && !take);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) out_q <= skid_q;
    end else if (vld_q[QW-1]) begin
      if (!out_vld_q || take) out_q  <= pipe_res;
      else                    skid_q <= pipe_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Checks
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a result with no result in the output register");

  a_zero_dens : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.zero_mass) |-> (out_q.dens_out == '0))
    else $error("zero mass result with nonzero density");

  a_thick_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((TW+1)'(out_q.thick_out) <= THICK_MAX))
    else $error("thickness above saturation limit");

  a_skid_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && take) |=> (out_vld_q && !skid_vld_q))
    else $error("skid did not drain into the output register");

endmodule

// ===== tb/tb_mass_weighted_layer_merge.sv =====
`timescale 1ns / 100ps

module tb_mass_weighted_layer_merge;
  import mwlm_pkg::*;

  localparam int unsigned LAYER_THICK_MAX = 100000000;
  localparam int unsigned PIPE_LATENCY    = 28;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned N_RANDOM        = 1200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  in_t  pending_reqs[$];
  out_t merged_expected[$];
  int   err_count = 0;
  int   cycle_count = 0;
  bit   stim_done = 1'b0;
  bit   hold_sender = 1'b0;
  int   send_gap = 0;
  int   recv_gap = 0;

  mass_weighted_layer_merge dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Queue appends
  function automatic void add_req(in_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic void add_exp(out_t o);
    merged_expected.insert(merged_expected.size(), o);
  endfunction

  // Exact merge of two layers, computed at full width
  function automatic out_t merge_layers(in_t r);
    out_t o;
    logic [127:0] m_a, m_b, m_tot, t_sum;
    m_a   = 128'(r.thick_a) * 128'(r.dens_a);
    m_b   = 128'(r.thick_b) * 128'(r.dens_b);
    m_tot = m_a + m_b;
    t_sum = 128'(r.thick_a) + 128'(r.thick_b);
    o.thick_out = (t_sum > LAYER_THICK_MAX) ? TW'(LAYER_THICK_MAX) : TW'(t_sum);
    if (m_tot == 0) begin
      o.dens_out  = '0;
      o.temp_out  = r.temp_a;
      o.dend_out  = r.dend_a;
      o.spher_out = r.spher_a;
      o.grain_out = r.grain_a;
      o.zero_mass = 1'b1;
    end else begin
      o.dens_out  = DW'(m_tot / t_sum);
      o.temp_out  = PW'((128'(r.temp_a) * m_a + 128'(r.temp_b) * m_b) / m_tot);
      o.dend_out  = PW'((128'(r.dend_a) * m_a + 128'(r.dend_b) * m_b) / m_tot);
      o.spher_out = PW'((128'(r.spher_a) * m_a + 128'(r.spher_b) * m_b) / m_tot);
      o.grain_out = GW'((128'(r.grain_a) * m_a + 128'(r.grain_b) * m_b) / m_tot);
      o.zero_mass = 1'b0;
    end
    return o;
  endfunction

  function automatic int pick_gap();
    int g;
    g = $urandom_range(0, 99);
    if (g < 55) return 0;
    if (g < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Thickness: mostly in range, sometimes at the top or beyond it
  function automatic logic [TW-1:0] rand_thick();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return TW'(LAYER_THICK_MAX);
      2: return TW'($urandom);
      3: return TW'($urandom_range(0, 1000));
      default: return TW'($urandom_range(0, LAYER_THICK_MAX));
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_dens();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return DW'($urandom);
    endcase
  endfunction

  function automatic logic [PW-1:0] rand_frac();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return PW'(65536);
      2: return PW'($urandom);
      default: return PW'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic in_t rand_req();
    in_t r;
    r.thick_a = rand_thick();
    r.dens_a  = rand_dens();
    r.temp_a  = PW'($urandom);
    r.dend_a  = rand_frac();
    r.spher_a = rand_frac();
    r.grain_a = GW'($urandom);
    r.thick_b = rand_thick();
    r.dens_b  = rand_dens();
    r.temp_b  = PW'($urandom);
    r.dend_b  = rand_frac();
    r.spher_b = rand_frac();
    r.grain_b = GW'($urandom);
    return r;
  endfunction

  // Driver: one request from the queue, random gaps between them
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        // accepted at the last rising edge
      end
    end
  end

  logic sent_ok;
  always @(posedge clk_i) sent_ok <= in_valid_i && !in_stall_o && rst_ni;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && sent_ok) begin
        add_exp(merge_layers(in_data_i));
        void'(pending_reqs.pop_front());
        send_gap = pick_gap();
      end
      if (in_valid_i && !sent_ok) begin
        // hold the stalled request
      end else if (hold_sender || pending_reqs.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_reqs[0];
      end
      // Receiver stalls
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else begin
        recv_gap = pick_gap();
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each merged layer with the oldest expectation
  always @(posedge clk_i) begin
    out_t exp_o;
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (merged_expected.size() == 0) begin
        $error("unexpected result %h", out_data_o);
        err_count++;
      end else begin
        exp_o = merged_expected.pop_front();
        if (out_data_o.thick_out !== exp_o.thick_out) begin
          $error("thick_out exp %0d got %0d", exp_o.thick_out, out_data_o.thick_out);
          err_count++;
        end
        if (out_data_o.dens_out !== exp_o.dens_out) begin
          $error("dens_out exp %0d got %0d", exp_o.dens_out, out_data_o.dens_out);
          err_count++;
        end
        if (out_data_o.temp_out !== exp_o.temp_out) begin
          $error("temp_out exp %0d got %0d", exp_o.temp_out, out_data_o.temp_out);
          err_count++;
        end
        if (out_data_o.dend_out !== exp_o.dend_out) begin
          $error("dend_out exp %0d got %0d", exp_o.dend_out, out_data_o.dend_out);
          err_count++;
        end
        if (out_data_o.spher_out !== exp_o.spher_out) begin
          $error("spher_out exp %0d got %0d", exp_o.spher_out, out_data_o.spher_out);
          err_count++;
        end
        if (out_data_o.grain_out !== exp_o.grain_out) begin
          $error("grain_out exp %0d got %0d", exp_o.grain_out, out_data_o.grain_out);
          err_count++;
        end
        if (out_data_o.zero_mass !== exp_o.zero_mass) begin
          $error("zero_mass exp %0d got %0d", exp_o.zero_mass, out_data_o.zero_mass);
          err_count++;
        end
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_mass_weighted_layer_merge: FAIL");
      $finish;
    end
  end

  initial begin
    in_t r;
    // Directed: extremes and zero-mass cases
    r = '0;
    add_req(r);
    r = '1;
    add_req(r);
    r = '1; r.dens_a = '0; r.dens_b = '0;
    add_req(r);
    r = '1; r.thick_a = '0; r.thick_b = '0;
    add_req(r);
    r = '1; r.thick_a = TW'(LAYER_THICK_MAX); r.thick_b = TW'(LAYER_THICK_MAX);
    r.dend_a = PW'(65536); r.spher_a = PW'(65536); r.dend_b = '0; r.spher_b = '0;
    add_req(r);
    r = '0; r.thick_a = TW'(1); r.dens_a = DW'(1); r.temp_a = '1; r.grain_a = '1;
    add_req(r);
    r = '0; r.thick_b = TW'(1); r.dens_b = DW'(1); r.temp_b = '1; r.grain_b = '1;
    r.temp_a = 17'h1abcd; r.grain_a = 24'h123456;
    add_req(r);
    r = '0; r.thick_a = TW'(LAYER_THICK_MAX); r.thick_b = TW'(1); r.dens_b = '1;
    add_req(r);
    r = '1; r.dens_b = DW'(1); r.thick_b = TW'(1);
    add_req(r);
    r = '0; r.thick_a = TW'(LAYER_THICK_MAX - 5); r.thick_b = TW'(5); r.dens_a = DW'(7);
    r.dens_b = DW'(3); r.temp_a = 17'd70000; r.temp_b = 17'd60000;
    add_req(r);
    r = '0; r.thick_a = TW'(1); r.thick_b = '1; r.dens_a = '1; r.temp_b = '1;
    add_req(r);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        // drain the pipe completely before sending more
        wait (pending_reqs.size() == 0);
        hold_sender = 1'b1;
        wait (merged_expected.size() == 0);
        hold_sender = 1'b0;
      end
      add_req(rand_req());
      if (pending_reqs.size() > 50) wait (pending_reqs.size() < 20);
    end
    wait (pending_reqs.size() == 0 && !in_valid_i);
    wait (merged_expected.size() == 0);
    repeat (PIPE_LATENCY + 10) @(posedge clk_i);
    if (err_count == 0 && merged_expected.size() == 0) begin
      $display("tb_mass_weighted_layer_merge: PASS");
    end else begin
      $display("tb_mass_weighted_layer_merge: FAIL");
    end
    $finish;
  end

endmodule

// ===== mass_weighted_layer_merge.f =====
hdl/mwlm_pkg.sv
hdl/mwlm_front.sv
hdl/mwlm_div_lane.sv
hdl/mass_weighted_layer_merge.sv
tb/tb_mass_weighted_layer_merge.sv
